FILE: hw/rtl/gpa_pkg.sv
// Shared constants, codes and control/status types of the GF(2) polynomial ALU.
package gpa_pkg;

  // Operand degree bound; coefficients above X^MAX_DEGREE are dropped.
  localparam int unsigned MAX_DEGREE = 31;

  // Internal widths derived from the degree bound
  localparam int unsigned OpW  = MAX_DEGREE + 1;
  localparam int unsigned ResW = 2 * MAX_DEGREE + 1;
  localparam int unsigned DegW = $clog2(ResW);
  localparam int unsigned CntW = $clog2(OpW);

  // Port field widths
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CoeffInW  = 32;
  localparam int unsigned CoeffOutW = 63;
  localparam int unsigned DegOutW   = 6;
  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 72;

  // Operation codes
  localparam logic [ModeW-1:0] MODE_ADD = 2'd0;
  localparam logic [ModeW-1:0] MODE_MUL = 2'd1;
  localparam logic [ModeW-1:0] MODE_DIV = 2'd2;

  // Datapath step commands
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_FIND,
    CMD_XOR,
    CMD_MUL,
    CMD_DIV
  } cmd_e;

  typedef struct packed {
    logic            x_top;
    logic            x_zero;
    logic            y_top;
    logic            acc_zero;
    logic [CntW-1:0] shift;
  } dp_status_t;

  typedef struct packed {
    cmd_e            cmd;
    logic            done;
    logic [DegW-1:0] degree;
    logic            div_zero;
  } seq_ctrl_t;

endpackage

FILE: hw/rtl/gpa_shift_xor_unit.sv
// Shared shift-and-XOR datapath: normalize, carry-less multiply and divide steps.
module gpa_shift_xor_unit (
  input  logic                     clk_i,
  input  gpa_pkg::cmd_e            cmd_i,
  input  logic [gpa_pkg::ModeW-1:0] mode_i,
  input  logic [gpa_pkg::OpW-1:0]  a_i,
  input  logic [gpa_pkg::OpW-1:0]  b_i,
  output gpa_pkg::dp_status_t      status_o,
  output logic [gpa_pkg::ResW-1:0] acc_o
);
  import gpa_pkg::*;

  // x: normalize target, later the aligned divisor
  // y: multiplier bits MSB first, or the division remainder
  // z: multiplicand, or the sum
  logic [OpW-1:0]  x_q, x_d, y_q, y_d, z_q, z_d;
  logic [ResW-1:0] acc_q, acc_d;
  logic [CntW-1:0] shift_q, shift_d;

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    acc_d   = acc_q;
    shift_d = shift_q;
    unique case (cmd_i)
      CMD_LOAD: begin
        acc_d   = '0;
        shift_d = '0;
        case (mode_i)
          MODE_ADD: begin
            x_d = a_i ^ b_i;
            y_d = '0;
            z_d = a_i ^ b_i;
          end
          MODE_MUL: begin
            x_d = a_i;
            y_d = b_i;
            z_d = a_i;
          end
          MODE_DIV: begin
            x_d = b_i;
            y_d = a_i;
            z_d = '0;
          end
          default: begin
            x_d = '0;
            y_d = '0;
            z_d = '0;
          end
        endcase
      end
      CMD_FIND: begin
        x_d     = x_q << 1;
        shift_d = shift_q + 1'b1;
      end
      CMD_XOR: acc_d = ResW'(z_q);
      CMD_MUL: begin
        acc_d = {acc_q[ResW-2:0], 1'b0} ^ (y_q[OpW-1] ? ResW'(z_q) : '0);
        y_d   = y_q << 1;
      end
      CMD_DIV: begin
        // divisor is aligned to the top bit; drop it where the remainder has one
        acc_d = {acc_q[ResW-2:0], y_q[OpW-1]};
        y_d   = (y_q ^ (y_q[OpW-1] ? x_q : '0)) << 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    acc_q   <= acc_d;
    shift_q <= shift_d;
  end

  assign status_o.x_top    = x_q[OpW-1];
  assign status_o.x_zero   = (x_q == '0);
  assign status_o.y_top    = y_q[OpW-1];
  assign status_o.acc_zero = (acc_q == '0);
  assign status_o.shift    = shift_q;
  assign acc_o             = acc_q;

endmodule

FILE: hw/rtl/gpa_sequencer.sv
// Sequencer stepping the shared unit and tracking the result degree.
module gpa_sequencer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gpa_pkg::ModeW-1:0] mode_i,
  input  gpa_pkg::dp_status_t       status_i,
  input  logic                      out_load_i,
  output gpa_pkg::seq_ctrl_t        ctrl_o,
  output logic                      ready_o
);
  import gpa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FIND = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DegW-1:0]  deg_q, deg_d;
  logic             dz_q, dz_d;
  cmd_e             cmd;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    deg_d   = deg_q;
    dz_d    = dz_q;
    cmd     = CMD_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd     = CMD_LOAD;
          mode_d  = mode_i;
          cnt_d   = '0;
          deg_d   = '0;
          dz_d    = 1'b0;
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        if (status_i.x_zero) begin
          // zero sum, zero multiplicand, zero divisor or unused mode
          dz_d    = (mode_q == MODE_DIV);
          state_d = ST_DONE;
        end else if (status_i.x_top) begin
          deg_d = DegW'(MAX_DEGREE) - DegW'(status_i.shift);
          case (mode_q)
            MODE_ADD: begin
              cmd     = CMD_XOR;
              state_d = ST_DONE;
            end
            MODE_MUL: state_d = ST_MUL;
            MODE_DIV: state_d = ST_DIV;
            default:  state_d = ST_DONE;
          endcase
        end else begin
          cmd = CMD_FIND;
        end
      end
      ST_MUL: begin
        cmd = CMD_MUL;
        // first multiplier bit sets the product degree
        if (status_i.acc_zero && status_i.y_top) begin
          deg_d = deg_q + DegW'(MAX_DEGREE) - DegW'(cnt_q);
        end
        if (cnt_q == CntW'(MAX_DEGREE)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV: begin
        cmd = CMD_DIV;
        // first quotient bit sets the quotient degree
        if (status_i.acc_zero && status_i.y_top) begin
          deg_d = DegW'(status_i.shift) - DegW'(cnt_q);
        end
        if (cnt_q == status_i.shift) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_ADD;
      cnt_q   <= '0;
      deg_q   <= '0;
      dz_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      deg_q   <= deg_d;
      dz_q    <= dz_d;
    end
  end

  assign ctrl_o.cmd      = cmd;
  assign ctrl_o.done     = (state_q == ST_DONE);
  assign ctrl_o.degree   = status_i.acc_zero ? '0 : deg_q;
  assign ctrl_o.div_zero = dz_q;
  assign ready_o         = (state_q == ST_IDLE);

endmodule

FILE: hw/rtl/gf2_polynomial_alu.sv
// Top level of the GF(2) polynomial ALU: stream ports, shared unit, output register.
//
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid_i/tready_o     tdata: mode, a_coeffs, b_coeffs
// m_axis   out  m_axis_tvalid_o/tready_i     tdata: result_coeffs, result_degree;
//                                            tuser: divide_by_zero
//
// Steps: the normalize pass (one shift per cycle) finds the top coefficient; add
//   then ends, while multiply and divide go on with one multiplier or quotient
//   bit per cycle through the shared shift-XOR unit.
// A zero sum, zero multiplicand, zero divisor or unused mode ends with no normalize shift.
// Reset: rst_ni clears the sequencer and the output valid; data needs no reset.
// Stalls: a result waits in the output register; input is taken again once the
//   result has moved into that register.
module gf2_polynomial_alu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [1:0] mode, [33:2] a_coeffs, [65:34] b_coeffs, [71:66] zero
  input  logic [gpa_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [62:0] result_coeffs, [68:63] result_degree, [71:69] zero
  output logic [gpa_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [0] divide_by_zero
  output logic                         m_axis_tuser_o
);
  import gpa_pkg::*;

  logic [ModeW-1:0]    in_mode;
  logic [CoeffInW-1:0] in_a, in_b;
  logic                in_accept;

  dp_status_t          status;
  seq_ctrl_t           ctrl;
  logic [ResW-1:0]     acc;
  logic                out_load;

  logic                   out_valid_q, out_valid_d;
  logic [CoeffOutW-1:0]   res_q;
  logic [DegOutW-1:0]     deg_q;
  logic                   dz_q;

  assign in_mode   = s_axis_tdata_i[1:0];
  assign in_a      = s_axis_tdata_i[33:2];
  assign in_b      = s_axis_tdata_i[65:34];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  gpa_shift_xor_unit u_unit (
    .clk_i    (clk_i),
    .cmd_i    (ctrl.cmd),
    .mode_i   (in_mode),
    .a_i      (in_a[OpW-1:0]),  // bits above X^MAX_DEGREE dropped
    .b_i      (in_b[OpW-1:0]),
    .status_o (status),
    .acc_o    (acc)
  );

  gpa_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .mode_i     (in_mode),
    .status_i   (status),
    .out_load_i (out_load),
    .ctrl_o     (ctrl),
    .ready_o    (s_axis_tready_o)
  );

  // output register, filled when empty or in the cycle its transaction completes
  assign out_load = ctrl.done && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= CoeffOutW'(acc);
      deg_q <= DegOutW'(ctrl.degree);
      dz_q  <= ctrl.div_zero;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, deg_q, res_q};
  assign m_axis_tuser_o  = dz_q;

`ifndef SYNTHESIS
  // one transaction in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  // divide by zero comes with an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && dz_q) |-> (res_q == '0 && deg_q == '0))
    else $error("divide by zero with nonzero result");

  // degree names the highest set coefficient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q != '0) |-> ((res_q >> deg_q) == CoeffOutW'(1)))
    else $error("result degree mismatch");
`endif

endmodule

FILE: verif/gf2_polynomial_alu_checker.sv
// Checker for the GF(2) polynomial ALU: predicts each result and compares it on the output.
module gf2_polynomial_alu_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [gpa_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  input  logic [gpa_pkg::OutDataW-1:0] m_axis_tdata_i,
  input  logic                         m_axis_tuser_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gpa_pkg::*;

  typedef struct packed {
    logic [CoeffOutW-1:0] coeffs;
    logic [DegOutW-1:0]   degree;
    logic                 div_zero;
  } poly_result_t;

  poly_result_t predicted_results[$];
  int unsigned  mismatch_count;

  // Index of the highest set coefficient, 0 for the zero polynomial.
  function automatic logic [DegOutW-1:0] top_coeff(logic [CoeffOutW-1:0] p);
    logic [DegOutW-1:0] d;
    d = '0;
    for (int k = 0; k < CoeffOutW; k++) begin
      if (p[k]) d = DegOutW'(k);
    end
    return d;
  endfunction

  function automatic logic [CoeffOutW-1:0] clmul_coeffs(logic [CoeffInW-1:0] a,
                                                        logic [CoeffInW-1:0] b);
    logic [CoeffOutW-1:0] acc;
    acc = '0;
    for (int k = 0; k < CoeffInW; k++) begin
      if (b[k]) acc ^= CoeffOutW'(a) << k;
    end
    return acc;
  endfunction

  // Long division, remainder dropped; each step lowers the remainder degree,
  // so 32 steps always suffice. Divisor is nonzero here.
  function automatic logic [CoeffOutW-1:0] quotient_coeffs(logic [CoeffInW-1:0] num,
                                                           logic [CoeffInW-1:0] den);
    logic [CoeffOutW-1:0] rem;
    logic [CoeffOutW-1:0] quot;
    int unsigned          dd;
    int unsigned          rd;
    rem  = CoeffOutW'(num);
    quot = '0;
    dd   = 32'(top_coeff(CoeffOutW'(den)));
    for (int k = 0; k < CoeffInW; k++) begin
      if (rem != '0) begin
        rd = 32'(top_coeff(rem));
        if (rd >= dd) begin
          quot[rd-dd] = 1'b1;
          rem ^= CoeffOutW'(den) << (rd - dd);
        end
      end
    end
    return quot;
  endfunction

  function automatic poly_result_t alu_result(logic [InDataW-1:0] tdata);
    logic [ModeW-1:0]    mode;
    logic [CoeffInW-1:0] a;
    logic [CoeffInW-1:0] b;
    poly_result_t        r;
    mode = tdata[ModeW-1:0];
    a    = tdata[ModeW +: CoeffInW];
    b    = tdata[ModeW+CoeffInW +: CoeffInW];
    r    = '0;
    case (mode)
      MODE_ADD: r.coeffs = CoeffOutW'(a ^ b);
      MODE_MUL: r.coeffs = clmul_coeffs(a, b);
      MODE_DIV: begin
        if (b == '0) r.div_zero = 1'b1;
        else         r.coeffs   = quotient_coeffs(a, b);
      end
      default: r = '0;   // unused mode answers all zero
    endcase
    r.degree = top_coeff(r.coeffs);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    poly_result_t got;
    poly_result_t want;
    if (!rst_ni) begin
      predicted_results.delete();
      mismatch_count = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // Results leave before a new input can produce one, so pop first.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.coeffs   = m_axis_tdata_i[CoeffOutW-1:0];
        got.degree   = m_axis_tdata_i[CoeffOutW +: DegOutW];
        got.div_zero = m_axis_tuser_i;
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result coeffs=%h degree=%0d dz=%b",
                     $time, got.coeffs, got.degree, got.div_zero);
        end else begin
          want = predicted_results.pop_front();
          if (got.coeffs !== want.coeffs || got.degree !== want.degree ||
              got.div_zero !== want.div_zero) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: mismatch exp coeffs=%h degree=%0d dz=%b, ",
                        "got coeffs=%h degree=%0d dz=%b"},
                       $time, want.coeffs, want.degree, want.div_zero,
                       got.coeffs, got.degree, got.div_zero);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predicted_results.push_back(alu_result(s_axis_tdata_i));
      fail_count_o  <= mismatch_count;
      outstanding_o <= predicted_results.size();
    end
  end

endmodule

FILE: verif/gf2_polynomial_alu_tb.sv
// Testbench top for the GF(2) polynomial ALU: clock, reset, stimulus, stalls and verdict.
module gf2_polynomial_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpa_pkg::*;

  // Mode code the block leaves unused; it must answer all zero.
  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;
  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 4000;
  // Drain time after the last expected result: worst case latency plus margin.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RANDOM_ITEMS = 1180;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [InDataW-1:0]   s_data = '0;   // [1:0] mode, [33:2] a, [65:34] b, [71:66] zero
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [OutDataW-1:0]  m_data;        // [62:0] coeffs, [68:63] degree, [71:69] zero
  logic                 m_user;        // [0] divide_by_zero
  logic                 steady = 1'b0; // set during the stretch with no idling
  int unsigned          fail_count;
  int unsigned          outstanding;
  int unsigned          quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  gf2_polynomial_alu dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  gf2_polynomial_alu_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  // Result side back-pressure: ~30% stall cycles, none during the steady stretch.
  always @(posedge clk_i) begin
    m_ready <= steady || ($urandom_range(99) >= 30);
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one operation and hold it until the block takes the transaction.
  // Random idle cycles go in front of it unless the steady stretch is on.
  task automatic send_op(logic [ModeW-1:0] mode, logic [CoeffInW-1:0] a,
                         logic [CoeffInW-1:0] b);
    if (!steady) begin
      while ($urandom_range(99) < 30) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, b, a, mode};
    do @(posedge clk_i); while (!s_ready);
  endtask

  // Operand mix: zero, all ones, single terms, low-degree and full-width values.
  function automatic logic [CoeffInW-1:0] rand_poly();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(31);
      3, 4:    return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [ModeW-1:0]    mode;
    logic [CoeffInW-1:0] a;
    logic [CoeffInW-1:0] b;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, each mode, and the documented corner cases.
    send_op(MODE_ADD, '0, '0);
    send_op(MODE_ADD, '1, '1);
    send_op(MODE_ADD, '1, '0);
    send_op(MODE_ADD, 32'h8000_0000, 32'h0000_0001);
    send_op(MODE_MUL, '0, 32'hdead_beef);
    send_op(MODE_MUL, '1, '1);                      // top degree 62
    send_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000);
    send_op(MODE_MUL, 32'h0000_0001, 32'h0000_0001);
    send_op(MODE_MUL, 32'h1234_5678, 32'h0000_0001);
    send_op(MODE_MUL, 32'hffff_ffff, 32'h0000_0003);
    send_op(MODE_DIV, '1, '0);                      // divide by zero
    send_op(MODE_DIV, '0, '0);                      // zero by zero
    send_op(MODE_DIV, 32'h0000_0003, 32'h8000_0000); // dividend of lower degree
    send_op(MODE_DIV, '1, 32'h0000_0001);
    send_op(MODE_DIV, 32'h8000_0000, 32'h8000_0000);
    send_op(MODE_DIV, '1, 32'h0000_0003);
    send_op(MODE_DIV, 32'h0000_0000, 32'h0000_0005); // zero dividend
    send_op(MODE_DIV, 32'h0001_1011, 32'h0000_0011); // remainder runs to zero
    send_op(MODE_DIV, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    send_op(MODE_SPARE, 32'hcafe_f00d, 32'h1234_5678);
    send_op(MODE_SPARE, '1, '1);
    send_op(MODE_SPARE, '0, '0);

    // Random: mostly real operations, the unused mode now and then.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 500) steady <= 1'b1;
      if (n == 800) steady <= 1'b0;
      mode = ($urandom_range(15) == 0) ? MODE_SPARE : ModeW'($urandom_range(2));
      a    = rand_poly();
      b    = rand_poly();
      send_op(mode, a, b);
    end
    s_valid <= 1'b0;

    // Let the checker count the last transaction before waiting on it.
    @(posedge clk_i);
    // Wait for every predicted result, then give the block time to misbehave.
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
